// File: sv/nps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nps_pkg;

  localparam int NPS_MAX_JOBS = 16;

  localparam int ARR_W    = 16;
  localparam int BURST_W  = 16;
  localparam int PRI_W    = 8;
  localparam int TIME_W   = 21;
  localparam int JIDX_W   = 4;
  localparam int WAIT_W   = 20;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 72;

  // controller to datapath commands
  typedef struct packed {
    logic load_wr;
    logic run_init;
    logic scan_init;
    logic scan_rd;
    logic decide;
    logic out_init;
    logic out_rd;
    logic out_load;
    logic run_clear;
  } nps_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic issue_done;
    logic eval_last;
    logic pick_vld;
    logic done_last;
    logic out_free;
    logic out_last;
  } nps_sts_t;

endpackage

`default_nettype wire

// File: sv/nonpreemptive_priority_scheduler_core.sv
`timescale 1ns / 1ps
`default_nettype none

// non-preemptive priority scheduler: jobs stream in one request per cycle (arrival, burst,
// priority); the request with tlast starts a run from time zero over all jobs held (a job
// beyond MAX_JOBS is dropped but its tlast still starts the run). each decision picks the
// arrived, unfinished job with the smallest priority, lower load index on a tie, and runs it
// to completion; with nothing arrived, time jumps to the earliest pending arrival. one result
// per job then leaves in load order with completion, turnaround and waiting time, tlast on
// the final one. a decision scans the job store through its single read port, and a run
// makes N dispatch decisions plus at most N idle jumps for N jobs held. each result is read
// from the store and then loaded into the output register once that register is free. input
// is refused during the run and while results are read out, and taken again as soon as the
// last result sits in the output register

module nonpreemptive_priority_scheduler_core #(
  parameter int MAX_JOBS = nps_pkg::NPS_MAX_JOBS   // 1 to 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // job requests
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // arrival_time [15:0], burst_length [31:16], priority_level [39:32]
  input  wire logic [nps_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic                             in_tlast,     // last_job
  // results
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // job_index [3:0], completion_time [24:4], turnaround_time [45:25],
  // waiting_time [65:46], zero [71:66]
  output logic [nps_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                  out_tlast     // last_result
);
  import nps_pkg::*;

  nps_cmd_t cmd;
  nps_sts_t sts;

  // sequencer: load, scan, decide, read out
  nps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tlast  (in_tlast),
    .sts       (sts),
    .cmd       (cmd)
  );

  // job stores, selection registers, clock and result register
  nps_datapath #(
    .MAX_JOBS (MAX_JOBS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// File: sv/nps_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module nps_datapath #(
  parameter int MAX_JOBS = nps_pkg::NPS_MAX_JOBS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic [nps_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire nps_pkg::nps_cmd_t                cmd,
  output nps_pkg::nps_sts_t                     sts,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [nps_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                  out_tlast
);
  import nps_pkg::*;

  localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CW = $clog2(MAX_JOBS + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_JOBS);
  localparam int PAD_W = OUT_TDATA_W - JIDX_W - 2 * TIME_W - WAIT_W;

  // job stores
  logic [ARR_W-1:0]   arr_mem   [MAX_JOBS];
  logic [BURST_W-1:0] burst_mem [MAX_JOBS];
  logic [PRI_W-1:0]   pri_mem   [MAX_JOBS];
  logic [TIME_W-1:0]  cmpl_mem  [MAX_JOBS];

  logic [ARR_W-1:0]   arr_q;
  logic [BURST_W-1:0] burst_q;
  logic [PRI_W-1:0]   pri_q;
  logic [TIME_W-1:0]  cmpl_q;

  logic [CW-1:0]       job_cnt_r;
  logic [CW-1:0]       idx_r;
  logic [CW-1:0]       done_r;
  logic [TIME_W-1:0]   time_r;
  logic [MAX_JOBS-1:0] fin_r;
  logic                rd_vld_r;
  logic [AW-1:0]       ev_idx_r;
  logic                pick_vld_r;
  logic [AW-1:0]       pick_idx_r;
  logic [PRI_W-1:0]    best_pri_r;
  logic [BURST_W-1:0]  best_burst_r;
  logic                have_next_r;
  logic [ARR_W-1:0]    next_arr_r;

  logic                out_vld_r;
  logic [JIDX_W-1:0]   out_jidx_r;
  logic [TIME_W-1:0]   out_cmpl_r;
  logic [TIME_W-1:0]   out_tat_r;
  logic [WAIT_W-1:0]   out_wait_r;
  logic                out_last_r;

  logic [AW-1:0]       rd_addr;
  logic                full;
  logic [CW-1:0]       cnt_m1;
  logic                ev_fin;
  logic                ev_arrived;
  logic                take_pick;
  logic                take_next;
  logic [TIME_W-1:0]   time_nxt;
  logic [TIME_W-1:0]   tat;
  logic [WAIT_W-1:0]   wait_t;

  assign rd_addr = idx_r[AW-1:0];
  assign full    = (job_cnt_r == MaxCnt);
  assign cnt_m1  = job_cnt_r - CW'(1);

  // scan evaluation of the entry read in the previous cycle
  assign ev_fin     = fin_r[ev_idx_r];
  assign ev_arrived = ({{(TIME_W - ARR_W){1'b0}}, arr_q} <= time_r);
  assign take_pick  = rd_vld_r && !ev_fin && ev_arrived &&
                      (!pick_vld_r || (pri_q < best_pri_r));
  assign take_next  = rd_vld_r && !ev_fin && !ev_arrived &&
                      (!have_next_r || (arr_q < next_arr_r));

  always_comb begin
    if (pick_vld_r) begin
      time_nxt = time_r + {{(TIME_W - BURST_W){1'b0}}, best_burst_r};
    end else begin
      time_nxt = {{(TIME_W - ARR_W){1'b0}}, next_arr_r};
    end
  end

  assign tat    = cmpl_q - {{(TIME_W - ARR_W){1'b0}}, arr_q};
  assign wait_t = WAIT_W'(tat - {{(TIME_W - BURST_W){1'b0}}, burst_q});

  // memories
  always_ff @(posedge clk) begin
    if (cmd.load_wr && !full) begin
      arr_mem[job_cnt_r[AW-1:0]]   <= in_tdata[ARR_W-1:0];
      burst_mem[job_cnt_r[AW-1:0]] <= in_tdata[ARR_W +: BURST_W];
      pri_mem[job_cnt_r[AW-1:0]]   <= in_tdata[ARR_W + BURST_W +: PRI_W];
    end
    if (cmd.decide && pick_vld_r) begin
      cmpl_mem[pick_idx_r] <= time_nxt;
    end
    if (cmd.scan_rd || cmd.out_rd) begin
      arr_q   <= arr_mem[rd_addr];
      burst_q <= burst_mem[rd_addr];
      pri_q   <= pri_mem[rd_addr];
      cmpl_q  <= cmpl_mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_cnt_r   <= '0;
      idx_r       <= '0;
      done_r      <= '0;
      time_r      <= '0;
      fin_r       <= '0;
      rd_vld_r    <= 1'b0;
      pick_vld_r  <= 1'b0;
      have_next_r <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      if (cmd.load_wr && !full) begin
        job_cnt_r <= job_cnt_r + CW'(1);
      end
      if (cmd.scan_init || cmd.out_init) begin
        idx_r <= '0;
      end else if (cmd.scan_rd || cmd.out_load) begin
        idx_r <= idx_r + CW'(1);
      end
      rd_vld_r <= cmd.scan_rd;
      if (cmd.scan_init) begin
        pick_vld_r  <= 1'b0;
        have_next_r <= 1'b0;
      end else begin
        if (take_pick) begin
          pick_vld_r <= 1'b1;
        end
        if (take_next) begin
          have_next_r <= 1'b1;
        end
      end
      if (cmd.run_init) begin
        time_r <= '0;
        done_r <= '0;
      end else if (cmd.decide) begin
        time_r <= time_nxt;
        if (pick_vld_r) begin
          done_r            <= done_r + CW'(1);
          fin_r[pick_idx_r] <= 1'b1;
        end
      end
      if (cmd.run_clear) begin
        job_cnt_r <= '0;
        time_r    <= '0;
        fin_r     <= '0;
      end
      if (cmd.out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      ev_idx_r <= rd_addr;
    end
    if (take_pick) begin
      pick_idx_r   <= ev_idx_r;
      best_pri_r   <= pri_q;
      best_burst_r <= burst_q;
    end
    if (take_next) begin
      next_arr_r <= arr_q;
    end
    if (cmd.out_load) begin
      out_jidx_r <= JIDX_W'(idx_r);
      out_cmpl_r <= cmpl_q;
      out_tat_r  <= tat;
      out_wait_r <= wait_t;
      out_last_r <= (idx_r == cnt_m1);
    end
  end

  always_comb begin
    sts.issue_done = (idx_r == job_cnt_r);
    sts.eval_last  = rd_vld_r && (CW'(ev_idx_r) == cnt_m1);
    sts.pick_vld   = pick_vld_r;
    sts.done_last  = (done_r == cnt_m1);
    sts.out_free   = !out_vld_r || out_tready;
    sts.out_last   = (idx_r == cnt_m1);
  end

  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_wait_r, out_tat_r, out_cmpl_r, out_jidx_r};

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    job_cnt_r <= MaxCnt)
    else $error("job count beyond store depth");

  a_idle_jump: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.decide && !pick_vld_r |-> have_next_r)
    else $error("no eligible job and no pending arrival");

  a_done_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.decide |-> done_r < job_cnt_r)
    else $error("dispatch after all jobs finished");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_vld_r || out_tready))
    else $error("result register overwritten");

endmodule

`default_nettype wire

// File: sv/nps_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module nps_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic               in_tlast,
  input  wire nps_pkg::nps_sts_t  sts,
  output nps_pkg::nps_cmd_t       cmd
);
  import nps_pkg::*;

  localparam logic [2:0] S_LOAD     = 3'd0;
  localparam logic [2:0] S_SCAN     = 3'd1;
  localparam logic [2:0] S_DECIDE   = 3'd2;
  localparam logic [2:0] S_OUT_RD   = 3'd3;
  localparam logic [2:0] S_OUT_FILL = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;

  assign in_tready = (state_r == S_LOAD);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        if (accept) begin
          cmd.load_wr = 1'b1;
          if (in_tlast) begin
            cmd.run_init  = 1'b1;
            cmd.scan_init = 1'b1;
            state_nxt     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_rd = !sts.issue_done;
        if (sts.eval_last) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide    = 1'b1;
        cmd.scan_init = 1'b1;
        if (sts.pick_vld && sts.done_last) begin
          cmd.out_init = 1'b1;
          state_nxt    = S_OUT_RD;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_OUT_RD: begin
        cmd.out_rd = 1'b1;
        state_nxt  = S_OUT_FILL;
      end
      S_OUT_FILL: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.out_last) begin
            cmd.run_clear = 1'b1;
            state_nxt     = S_LOAD;
          end else begin
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: tb/nps_checker.sv
`timescale 1ns / 1ps

// watches both streams, predicts each job set's schedule and compares the results
module nps_checker
  import nps_pkg::*;
#(
  parameter int MAX_JOBS = NPS_MAX_JOBS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tlast,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tlast,
  output int                     fail_count,
  output int                     open_reports
);

  typedef struct packed {
    logic [JIDX_W-1:0] job_index;
    logic [TIME_W-1:0] completion_time;
    logic [TIME_W-1:0] turnaround_time;
    logic [WAIT_W-1:0] waiting_time;
    logic              last_result;
  } job_report_t;

  logic [ARR_W-1:0]   job_arrival [MAX_JOBS];
  logic [BURST_W-1:0] job_burst   [MAX_JOBS];
  logic [PRI_W-1:0]   job_prio    [MAX_JOBS];
  int                 jobs_held;
  job_report_t        report_q [$];

  initial begin
    fail_count   = 0;
    open_reports = 0;
    jobs_held    = 0;
  end

  // non-preemptive priority schedule over the held set, one report per job in load order
  task automatic schedule_held_jobs();
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] finish_at [MAX_JOBS];
    bit                served_flag [MAX_JOBS];
    logic [ARR_W-1:0]  next_arr;
    bit                have_next;
    int                served;
    int                pick;
    job_report_t       rep;
    now    = '0;
    served = 0;
    for (int i = 0; i < MAX_JOBS; i++) begin
      served_flag[i] = 1'b0;
      finish_at[i]   = '0;
    end
    while (served < jobs_held) begin
      pick      = -1;
      have_next = 1'b0;
      next_arr  = '0;
      for (int i = 0; i < jobs_held; i++) begin
        if (!served_flag[i]) begin
          if (TIME_W'(job_arrival[i]) <= now) begin
            // strict less-than keeps the lower index on a tie
            if (pick < 0 || job_prio[i] < job_prio[pick]) pick = i;
          end else if (!have_next || job_arrival[i] < next_arr) begin
            next_arr  = job_arrival[i];
            have_next = 1'b1;
          end
        end
      end
      if (pick >= 0) begin
        now               = now + TIME_W'(job_burst[pick]);
        finish_at[pick]   = now;
        served_flag[pick] = 1'b1;
        served++;
      end else begin
        // nothing arrived yet: jump to the earliest pending arrival
        now = TIME_W'(next_arr);
      end
    end
    for (int i = 0; i < jobs_held; i++) begin
      rep.job_index       = JIDX_W'(i);
      rep.completion_time = finish_at[i];
      rep.turnaround_time = finish_at[i] - TIME_W'(job_arrival[i]);
      rep.waiting_time    = WAIT_W'(rep.turnaround_time - TIME_W'(job_burst[i]));
      rep.last_result     = (i == jobs_held - 1);
      report_q.push_back(rep);
    end
    jobs_held = 0;
  endtask

  // sampled mid-cycle: these values decide the handshakes at the next rising edge
  always @(negedge clk) begin
    job_report_t want;
    job_report_t got;
    if (!rst_n) begin
      jobs_held = 0;
      report_q.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        if (jobs_held < MAX_JOBS) begin
          job_arrival[jobs_held] = in_tdata[15:0];
          job_burst[jobs_held]   = in_tdata[31:16];
          job_prio[jobs_held]    = in_tdata[39:32];
          jobs_held++;
        end
        // a dropped request still starts the run if it carries tlast
        if (in_tlast) schedule_held_jobs();
      end
      if (out_tvalid && out_tready) begin
        got.job_index       = out_tdata[3:0];
        got.completion_time = out_tdata[24:4];
        got.turnaround_time = out_tdata[45:25];
        got.waiting_time    = out_tdata[65:46];
        got.last_result     = out_tlast;
        if (report_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result: expected none, got idx %0d ct %0d tat %0d wt %0d last %0b",
                   $time, got.job_index, got.completion_time, got.turnaround_time,
                   got.waiting_time, got.last_result);
        end else begin
          want = report_q.pop_front();
          if (got !== want || out_tdata[71:66] !== '0) begin
            fail_count++;
            $display("%0t: result mismatch: expected idx %0d ct %0d tat %0d wt %0d last %0b pad 0",
                     $time, want.job_index, want.completion_time, want.turnaround_time,
                     want.waiting_time, want.last_result);
            $display("%0t:                   actual idx %0d ct %0d tat %0d wt %0d last %0b pad %0h",
                     $time, got.job_index, got.completion_time, got.turnaround_time,
                     got.waiting_time, got.last_result, out_tdata[71:66]);
          end
        end
      end
    end
    open_reports = report_q.size();
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import nps_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_JOBS  = 125;
  localparam int PHASE_JOBS   = 60;   // requests per idling phase
  localparam int DRAIN_CYCLES = 40;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  int send_idle_pct = 30;
  int sink_idle_pct = 59;
  int jobs_sent     = 0;
  int cycle_count   = 0;
  int fail_count;
  int open_reports;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  nonpreemptive_priority_scheduler_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  nps_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .fail_count   (fail_count),
    .open_reports (open_reports)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("nonpreemptive_priority_scheduler_core verification failed");
      $finish;
    end
  end

  // called at a rising edge, returns at the edge that accepts the request
  task automatic push_job(input logic [ARR_W-1:0] arr, input logic [BURST_W-1:0] burst,
                          input logic [PRI_W-1:0] prio, input logic last);
    if (jobs_sent == PHASE_JOBS) begin
      send_idle_pct = 59;
      sink_idle_pct = 30;
    end else if (jobs_sent == 2 * PHASE_JOBS) begin
      send_idle_pct = 0;
      sink_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      // junk on the bus while idle
      in_tvalid <= 1'b0;
      in_tdata  <= IN_TDATA_W'({$urandom(), $urandom()});
      in_tlast  <= 1'($urandom_range(1));
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {prio, burst, arr};
    in_tlast  <= last;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    jobs_sent++;
  endtask

  initial begin
    int random_sent;
    int set_len;
    int pick;
    int spread;
    logic [ARR_W-1:0]   arr;
    logic [BURST_W-1:0] burst;
    logic [PRI_W-1:0]   prio;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // zero everything
    push_job(16'd0, 16'd0, 8'd0, 1'b1);
    // lone job at the top of every range, time must jump to its arrival
    push_job(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
    // equal priorities: load order breaks the tie
    push_job(16'd0, 16'd5, 8'd7, 1'b0);
    push_job(16'd1, 16'd3, 8'd7, 1'b0);
    push_job(16'd1, 16'd2, 8'd7, 1'b1);
    // idle gap at start and again mid-run, priority beats load order
    push_job(16'd30, 16'd4, 8'd200, 1'b0);
    push_job(16'd12, 16'd6, 8'd9, 1'b0);
    push_job(16'd12, 16'd1, 8'd0, 1'b1);
    // full store of maximal jobs, then a dropped request whose tlast starts the run
    for (int k = 0; k < 16; k++) begin
      push_job(16'hFFFF, 16'hFFFF, (k % 2) ? 8'h00 : 8'hFF, 1'b0);
    end
    push_job(16'h1234, 16'h5678, 8'h5A, 1'b1);

    random_sent = 0;
    while (random_sent < RANDOM_JOBS) begin
      pick = $urandom_range(9);
      if (pick < 7) set_len = $urandom_range(1, 6);
      else if (pick < 9) set_len = $urandom_range(7, 16);
      else set_len = $urandom_range(17, 19);   // overflows the store
      spread = $urandom_range(3);
      for (int k = 0; k < set_len; k++) begin
        case (spread)
          0: begin
            // dense arrivals, short bursts, few priorities: lots of ties
            arr   = ARR_W'($urandom_range(20));
            burst = BURST_W'($urandom_range(8));
            prio  = PRI_W'($urandom_range(3));
          end
          1: begin
            // sparse arrivals leave idle gaps
            arr   = ARR_W'($urandom_range(200));
            burst = BURST_W'($urandom_range(30));
            prio  = PRI_W'($urandom());
          end
          default: begin
            arr   = ARR_W'($urandom());
            burst = BURST_W'($urandom());
            prio  = PRI_W'($urandom());
          end
        endcase
        push_job(arr, burst, prio, k == set_len - 1);
        random_sent++;
      end
    end
    in_tvalid <= 1'b0;

    while (open_reports != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("nonpreemptive_priority_scheduler_core verification clean");
    end else begin
      $display("nonpreemptive_priority_scheduler_core verification failed");
    end
    $finish;
  end

endmodule
